### hw/rtl/sdc_pkg.sv
// sdc_pkg: shared widths, result codes, pipeline control struct and the
// power-of-ten table for the scaled decimal compare block.
// No dependencies.
`timescale 1ns / 1ps

package sdc_pkg;

  // field and datapath widths
  localparam int unsigned LIMB_W        = 32;
  localparam int unsigned MANT_LO_W     = 64;
  localparam int unsigned MANT_HI_W     = 32;
  localparam int unsigned MANT_W        = MANT_LO_W + MANT_HI_W;
  localparam int unsigned LIMBS         = MANT_W / LIMB_W;
  localparam int unsigned PP_W          = 2 * LIMB_W;
  localparam int unsigned ROW_W         = MANT_W + LIMB_W;
  localparam int unsigned PART_W        = MANT_W + 2 * LIMB_W;
  localparam int unsigned PROD_W        = 2 * MANT_W;
  localparam int unsigned SCALE_W       = 5;
  localparam int unsigned MAX_SCALE_DEF = 28;

  // result codes, two's complement in two bits
  typedef enum logic [1:0] {
    ORD_EQ   = 2'b00,
    ORD_GT   = 2'b01,
    ORD_LESS = 2'b11
  } order_e;

  // per-item control that rides along with the datapath
  typedef struct packed {
    logic   decided;  // answer known without the magnitude compare
    order_e ord_fix;  // that answer
    logic   neg;      // both operands negative, flip the magnitude order
    logic   scale_a;  // first operand is the one multiplied up
  } ctl_t;

  // ten to the power d, d in 0..28
  function automatic logic [MANT_W-1:0] pow10(input logic [SCALE_W-1:0] d);
    logic [MANT_W-1:0] p;
    case (d)
      5'd0:  p = 96'd1;
      5'd1:  p = 96'd10;
      5'd2:  p = 96'd100;
      5'd3:  p = 96'd1000;
      5'd4:  p = 96'd10000;
      5'd5:  p = 96'd100000;
      5'd6:  p = 96'd1000000;
      5'd7:  p = 96'd10000000;
      5'd8:  p = 96'd100000000;
      5'd9:  p = 96'd1000000000;
      5'd10: p = 96'd10000000000;
      5'd11: p = 96'd100000000000;
      5'd12: p = 96'd1000000000000;
      5'd13: p = 96'd10000000000000;
      5'd14: p = 96'd100000000000000;
      5'd15: p = 96'd1000000000000000;
      5'd16: p = 96'd10000000000000000;
      5'd17: p = 96'd100000000000000000;
      5'd18: p = 96'd1000000000000000000;
      5'd19: p = 96'd10000000000000000000;
      5'd20: p = 96'd100000000000000000000;
      5'd21: p = 96'd1000000000000000000000;
      5'd22: p = 96'd10000000000000000000000;
      5'd23: p = 96'd100000000000000000000000;
      5'd24: p = 96'd1000000000000000000000000;
      5'd25: p = 96'd10000000000000000000000000;
      5'd26: p = 96'd100000000000000000000000000;
      5'd27: p = 96'd1000000000000000000000000000;
      5'd28: p = 96'd10000000000000000000000000000;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

### hw/rtl/scaled_decimal_compare.sv
// scaled_decimal_compare: seven-stage pipelined compare of two signed
// scaled decimals with 96-bit mantissas. Depends on sdc_pkg.
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+------------------------------------
//   input   | in_valid_i  | in_stall_o  | a_/b_ mant_low, mant_high, scale, negative
//   output  | out_valid_o | out_stall_i | order_o
//
// An item enters in every cycle while in_stall_o is low; its result passes
// through the seven registered stages, a depth set by the 96 x 96 bit multiply
// by the power of ten (nine 32 x 32 partial products, then three add stages)
// and the final 192-bit compare. Reset clears only the stage valid bits.
// All stages move together; a stall of the output register holds the whole
// pipeline and the input stall follows it in the same cycle.
`timescale 1ns / 1ps

module scaled_decimal_compare #(
  parameter int unsigned MAX_SCALE = sdc_pkg::MAX_SCALE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [sdc_pkg::MANT_LO_W-1:0]   a_mant_low_i,
  input  logic [sdc_pkg::MANT_HI_W-1:0]   a_mant_high_i,
  input  logic [sdc_pkg::SCALE_W-1:0]     a_scale_i,
  input  logic                            a_negative_i,
  input  logic [sdc_pkg::MANT_LO_W-1:0]   b_mant_low_i,
  input  logic [sdc_pkg::MANT_HI_W-1:0]   b_mant_high_i,
  input  logic [sdc_pkg::SCALE_W-1:0]     b_scale_i,
  input  logic                            b_negative_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [1:0]               order_o
);

  localparam int unsigned LW = sdc_pkg::LIMB_W;
  localparam int unsigned NL = sdc_pkg::LIMBS;
  localparam logic [sdc_pkg::SCALE_W-1:0] MAX_SC = sdc_pkg::SCALE_W'(MAX_SCALE);

  // whole pipeline advances unless the output register is held
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // ---------------- stage 1: decode, clamp, pick operand to scale --------
  logic [sdc_pkg::MANT_W-1:0]  a_m, b_m;
  logic [sdc_pkg::SCALE_W-1:0] sa, sb;
  logic                        both_zero;
  sdc_pkg::ctl_t               s1_ctl_d;
  logic [sdc_pkg::MANT_W-1:0]  s1_ms_d, s1_mo_d;
  logic [sdc_pkg::SCALE_W-1:0] s1_dif_d;

  always_comb begin
    a_m       = {a_mant_high_i, a_mant_low_i};
    b_m       = {b_mant_high_i, b_mant_low_i};
    sa        = (a_scale_i > MAX_SC) ? MAX_SC : a_scale_i;
    sb        = (b_scale_i > MAX_SC) ? MAX_SC : b_scale_i;
    both_zero = (a_m == '0) && (b_m == '0);
    s1_ctl_d.decided = both_zero || (a_negative_i != b_negative_i);
    s1_ctl_d.ord_fix = both_zero ? sdc_pkg::ORD_EQ
                     : (a_negative_i ? sdc_pkg::ORD_LESS : sdc_pkg::ORD_GT);
    s1_ctl_d.neg     = a_negative_i;
    if (sa > sb) begin
      s1_ctl_d.scale_a = 1'b0;
      s1_ms_d          = b_m;
      s1_mo_d          = a_m;
      s1_dif_d         = sa - sb;
    end else begin
      s1_ctl_d.scale_a = 1'b1;
      s1_ms_d          = a_m;
      s1_mo_d          = b_m;
      s1_dif_d         = sb - sa;
    end
  end

  // ---------------- stage registers ----------------
  logic [6:0]                  vld_q;
  sdc_pkg::ctl_t               s1_ctl_q, s2_ctl_q, s3_ctl_q, s4_ctl_q, s5_ctl_q, s6_ctl_q;
  logic [sdc_pkg::MANT_W-1:0]  s1_ms_q, s1_mo_q, s2_ms_q, s2_mo_q;
  logic [sdc_pkg::MANT_W-1:0]  s3_mo_q, s4_mo_q, s5_mo_q, s6_mo_q;
  logic [sdc_pkg::SCALE_W-1:0] s1_dif_q;
  logic [sdc_pkg::MANT_W-1:0]  s2_pow_q;
  logic [sdc_pkg::PP_W-1:0]    s3_pp_q [NL][NL];
  logic [sdc_pkg::ROW_W-1:0]   s4_row_q [NL];
  logic [sdc_pkg::PART_W-1:0]  s5_part_q;
  logic [sdc_pkg::ROW_W-1:0]   s5_row_q;
  logic [sdc_pkg::PROD_W-1:0]  s6_prod_q;
  logic [1:0]                  order_q;

  // ---------------- stage 3 partial products ----------------
  logic [sdc_pkg::PP_W-1:0] s3_pp_d [NL][NL];
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      for (int j = 0; j < NL; j++) begin
        s3_pp_d[i][j] = {{LW{1'b0}}, s2_ms_q[i*LW +: LW]} *
                        {{LW{1'b0}}, s2_pow_q[j*LW +: LW]};
      end
    end
  end

  // ---------------- stage 4 rows: mantissa times one power limb ----------
  logic [sdc_pkg::ROW_W-1:0] s4_row_d [NL];
  always_comb begin
    for (int j = 0; j < NL; j++) begin
      s4_row_d[j] = {s3_pp_q[2][j], s3_pp_q[0][j]}
                  + {{LW{1'b0}}, s3_pp_q[1][j], {LW{1'b0}}};
    end
  end

  // ---------------- stage 5 and 6 row accumulation ----------------
  logic [sdc_pkg::PART_W-1:0] s5_part_d;
  logic [sdc_pkg::PROD_W-1:0] s6_prod_d;
  assign s5_part_d = {{LW{1'b0}}, s4_row_q[0]} + {s4_row_q[1], {LW{1'b0}}};
  assign s6_prod_d = {{LW{1'b0}}, s5_part_q} + {s5_row_q, {(2*LW){1'b0}}};

  // ---------------- stage 7 magnitude compare and sign ----------------
  logic [sdc_pkg::PROD_W-1:0] mo_ext;
  logic                       gt, lt, a_gt, a_lt;
  logic [1:0]                 order_d;
  always_comb begin
    mo_ext = {{(sdc_pkg::PROD_W - sdc_pkg::MANT_W){1'b0}}, s6_mo_q};
    gt     = s6_prod_q > mo_ext;
    lt     = s6_prod_q < mo_ext;
    // scaled vs other, turned into first vs second, then sign flip
    a_gt   = (s6_ctl_q.scale_a ^ s6_ctl_q.neg) ? gt : lt;
    a_lt   = (s6_ctl_q.scale_a ^ s6_ctl_q.neg) ? lt : gt;
    if (s6_ctl_q.decided) begin
      order_d = s6_ctl_q.ord_fix;
    end else if (a_gt) begin
      order_d = sdc_pkg::ORD_GT;
    end else if (a_lt) begin
      order_d = sdc_pkg::ORD_LESS;
    end else begin
      order_d = sdc_pkg::ORD_EQ;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[5:0], in_valid_i};
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ctl_q  <= s1_ctl_d;
      s1_ms_q   <= s1_ms_d;
      s1_mo_q   <= s1_mo_d;
      s1_dif_q  <= s1_dif_d;
      s2_ctl_q  <= s1_ctl_q;
      s2_ms_q   <= s1_ms_q;
      s2_mo_q   <= s1_mo_q;
      s2_pow_q  <= sdc_pkg::pow10(s1_dif_q);
      s3_ctl_q  <= s2_ctl_q;
      s3_mo_q   <= s2_mo_q;
      s3_pp_q   <= s3_pp_d;
      s4_ctl_q  <= s3_ctl_q;
      s4_mo_q   <= s3_mo_q;
      s4_row_q  <= s4_row_d;
      s5_ctl_q  <= s4_ctl_q;
      s5_mo_q   <= s4_mo_q;
      s5_part_q <= s5_part_d;
      s5_row_q  <= s4_row_q[2];
      s6_ctl_q  <= s5_ctl_q;
      s6_mo_q   <= s5_mo_q;
      s6_prod_q <= s6_prod_d;
      order_q   <= order_d;
    end
  end

  assign out_valid_o = vld_q[6];
  assign order_o     = signed'(order_q);

`ifndef NO_ASSERTIONS
  // input is held only while a finished result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // a delivered result is always one of the three codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (order_o != 2'sb10))
    else $error("invalid order code");

  // both mantissas zero always decodes to a fixed equal answer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && adv && both_zero) |=>
      (s1_ctl_q.decided && s1_ctl_q.ord_fix == sdc_pkg::ORD_EQ))
    else $error("zero operands not decoded as equal");

  // the scale difference never exceeds the clamp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> (s1_dif_q <= MAX_SC))
    else $error("scale difference out of range");
`endif

endmodule
